### hdl/avts_pkg.sv
// ----------------------------------------------------------------------------
// Timestamp sync matcher package
// Shared types, status codes and register indexes.
// ----------------------------------------------------------------------------
package avts_pkg;

	localparam int TIME_W = 63;
	localparam int SRC_W = 8;
	localparam int HANDLE_W = 16;
	localparam int REG_W = 32;
	localparam int DROP_W = 5;

	typedef logic [2:0] status_t;
	localparam status_t ST_MATCHED = 3'd0;
	localparam status_t ST_REUSED = 3'd1;
	localparam status_t ST_NO_VIDEO = 3'd2;
	localparam status_t ST_BAD_TIME = 3'd3;
	localparam status_t ST_STORED = 3'd4;
	localparam status_t ST_FULL = 3'd5;

	localparam logic REG_SYNC_DIFF = 1'b0;
	localparam logic REG_VIDEO_LAG = 1'b1;

	typedef struct packed {
		logic signed [TIME_W-1:0] t;
		logic [SRC_W-1:0] src;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	// Command broadcast to every cell.
	typedef struct packed {
		logic push;   // append at the tail
		logic shift;  // every cell takes its right neighbour's content (the last keeps its own)
		logic scan;   // rotate head cell to tail while classifying
	} cell_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE, S_PURGE, S_SEARCH, S_POP, S_OUT
	} state_t;

endpackage

### hdl/avts_cell.sv
// ----------------------------------------------------------------------------
// Queue cell
// One queue entry; shifts towards the head or loads a new item.
// ----------------------------------------------------------------------------
module avts_cell (
	input  logic                clk,
	input  avts_pkg::cell_ctl_t ctl,
	input  logic                load_here,
	input  avts_pkg::entry_t    new_entry,
	input  avts_pkg::entry_t    right_entry,
	output avts_pkg::entry_t    entry
);
	import avts_pkg::*;

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (load_here) begin
			entry_q <= new_entry;
		end else if (ctl.shift || ctl.scan) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;
endmodule

### hdl/av_timestamp_sync_matcher.sv
// ----------------------------------------------------------------------------
// Audio/video timestamp sync matcher
// Video descriptors in a shifting row of cells; audio items purge and match.
// ----------------------------------------------------------------------------
// Channel | Direction | Signals
// in      | input     | in_valid, in_stall, kind, frame_time, video_source, frame_handle
// out     | output    | out_valid, out_stall, status, match_time, ..., dropped_count
// cfg     | input     | cfg_we, cfg_index, cfg_wdata
// A video item, a bad audio time or an audio item on an empty queue goes straight
// to its result. Any other audio item first rotates the queue once for the purge;
// if entries remain, it rotates them once more for the search, then shifts out
// one popped entry at a time: the best match and all entries ahead of it.
// Reset clears the count and the last frame and loads the register defaults; cells need none.
// A stalled result holds in the output register; no item is taken meanwhile.
// ----------------------------------------------------------------------------
module av_timestamp_sync_matcher #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           kind,
	input  logic signed [avts_pkg::TIME_W-1:0] frame_time,
	input  logic [avts_pkg::SRC_W-1:0]     video_source,
	input  logic [avts_pkg::HANDLE_W-1:0]  frame_handle,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     status,
	output logic signed [avts_pkg::TIME_W-1:0] match_time,
	output logic [avts_pkg::SRC_W-1:0]     match_source,
	output logic [avts_pkg::HANDLE_W-1:0]  match_handle,
	output logic [avts_pkg::HANDLE_W-1:0]  audio_tag,
	output logic [avts_pkg::DROP_W-1:0]    dropped_count,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [avts_pkg::REG_W-1:0]     cfg_wdata
);
	import avts_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = $clog2(QUEUE_DEPTH);

	state_t state_q, state_d;
	logic [REG_W-1:0] sync_q, lag_q;
	logic [CW-1:0] count_q, wr_q, idx_q, best_q, popn_q;
	logic signed [TIME_W-1:0] t_q, last_t_q;
	logic [SRC_W-1:0] last_s_q;
	logic [HANDLE_W-1:0] last_h_q, tag_q;
	logic found_q;
	logic [TIME_W:0] best_gap_q;
	logic [CW:0] drop_q;

	entry_t cells [QUEUE_DEPTH];
	entry_t rights [QUEUE_DEPTH];
	entry_t new_entry, head;
	cell_ctl_t ctl;
	logic [CW-1:0] load_pos;
	logic load_en;

	logic signed [TIME_W:0] thr, diff;
	logic [TIME_W:0] g;
	logic keep, win;
	logic accept;
	logic signed [TIME_W:0] dl;
	logic [TIME_W:0] g_last;

	assign head = cells[0];
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || out_valid;
	assign thr = $signed({t_q[TIME_W-1], t_q}) -
		$signed({{(TIME_W-REG_W+1){1'b0}}, lag_q});
	assign keep = !($signed({head.t[TIME_W-1], head.t}) < thr);
	assign diff = $signed({head.t[TIME_W-1], head.t}) - $signed({t_q[TIME_W-1], t_q});
	assign g = diff[TIME_W] ? (TIME_W+1)'(-diff) : diff;
	assign win = g <= {{(TIME_W-REG_W+1){1'b0}}, sync_q};
	assign dl = $signed({last_t_q[TIME_W-1], last_t_q}) - $signed({t_q[TIME_W-1], t_q});
	assign g_last = dl[TIME_W] ? (TIME_W+1)'(-dl) : dl;

	always_comb begin
		ctl = '0;
		load_en = 1'b0;
		load_pos = count_q;
		new_entry = head;
		unique case (state_q)
			S_IDLE: begin
				ctl.push = accept && !kind && (count_q < CW'(QUEUE_DEPTH));
				load_en = ctl.push;
				new_entry = '{t: frame_time, src: video_source, handle: frame_handle};
			end
			S_PURGE: begin
				ctl.scan = 1'b1;
				load_en = keep;
				load_pos = wr_q + count_q - idx_q - 1'b1;
			end
			S_SEARCH: begin
				ctl.scan = 1'b1;
				load_en = 1'b1;
				load_pos = count_q - 1'b1;
			end
			S_POP: ctl.shift = found_q;
			default: ;
		endcase
	end

	genvar k;
	generate
		for (k = 0; k < QUEUE_DEPTH; k++) begin : g_cells
			if (k == QUEUE_DEPTH - 1) begin : g_last
				assign rights[k] = cells[k];
			end else begin : g_mid
				assign rights[k] = cells[k+1];
			end
			avts_cell u_cell (
				.clk(clk), .ctl(ctl),
				.load_here(load_en && (load_pos[IW-1:0] == IW'(k)) &&
					(load_pos < CW'(QUEUE_DEPTH))),
				.new_entry(new_entry), .right_entry(rights[k]), .entry(cells[k])
			);
		end
	endgenerate

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept) begin
				if (kind && !frame_time[TIME_W-1] && frame_time != '0)
					state_d = (count_q == '0) ? S_OUT : S_PURGE;
				else state_d = S_OUT;
			end
			S_PURGE: if (idx_q == count_q - 1'b1)
				state_d = (wr_q + CW'(keep) == '0) ? S_OUT : S_SEARCH;
			S_SEARCH: if (idx_q == count_q - 1'b1) state_d = S_POP;
			S_POP: if (!found_q || popn_q == best_q) state_d = S_OUT;
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sync_q <= 32'd40000;
			lag_q <= 32'd500000;
			count_q <= '0;
			last_t_q <= '0;
			last_s_q <= '0;
			last_h_q <= '0;
			out_valid <= 1'b0;
			idx_q <= '0;
			wr_q <= '0;
			found_q <= 1'b0;
			drop_q <= '0;
			t_q <= '0;
			tag_q <= '0;
			best_q <= '0;
			popn_q <= '0;
			best_gap_q <= '0;
			status <= ST_MATCHED;
			match_time <= '0;
			match_source <= '0;
			match_handle <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == REG_SYNC_DIFF) sync_q <= cfg_wdata;
				else lag_q <= cfg_wdata;
			end
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (accept) begin
					t_q <= frame_time;
					tag_q <= kind ? frame_handle : '0;
					idx_q <= '0;
					wr_q <= '0;
					found_q <= 1'b0;
					drop_q <= '0;
					if (!kind) begin
						status <= (count_q < CW'(QUEUE_DEPTH)) ? ST_STORED : ST_FULL;
						if (count_q < CW'(QUEUE_DEPTH)) count_q <= count_q + 1'b1;
					end else if (frame_time[TIME_W-1] || frame_time == '0) begin
						status <= ST_BAD_TIME;
					end else begin
						status <= ST_NO_VIDEO;
					end
				end
				S_PURGE: begin
					if (keep) wr_q <= wr_q + 1'b1;
					else drop_q <= drop_q + 1'b1;
					if (idx_q == count_q - 1'b1) begin
						count_q <= wr_q + CW'(keep);
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SEARCH: begin
					idx_q <= idx_q + 1'b1;
					if (win && (!found_q || g < best_gap_q)) begin
						found_q <= 1'b1;
						best_gap_q <= g;
						best_q <= idx_q;
						match_time <= head.t;
						match_source <= head.src;
						match_handle <= head.handle;
					end
					if (idx_q == count_q - 1'b1) popn_q <= '0;
				end
				S_POP: begin
					if (found_q) begin
						count_q <= count_q - 1'b1;
						popn_q <= popn_q + 1'b1;
						if (popn_q == '0) drop_q <= drop_q + (CW+1)'(best_q);
					end
				end
				S_OUT: begin
					out_valid <= 1'b1;
					if (status == ST_NO_VIDEO) begin
						if (found_q) begin
							status <= ST_MATCHED;
							last_t_q <= match_time;
							last_s_q <= match_source;
							last_h_q <= match_handle;
						end else if (last_t_q != '0 &&
								g_last <= {{(TIME_W-REG_W){1'b0}}, sync_q, 1'b0}) begin
							status <= ST_REUSED;
							match_time <= last_t_q;
							match_source <= last_s_q;
							match_handle <= last_h_q;
						end
					end
				end
				default: ;
			endcase
			if (state_q == S_IDLE && accept) begin
				match_time <= '0;
				match_source <= '0;
				match_handle <= '0;
			end
		end
	end

	assign audio_tag = tag_q;
	assign dropped_count = (drop_q > (CW+1)'(31)) ? DROP_W'(31) : DROP_W'(drop_q);

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> in_stall)
		else $error("input taken while a result waits");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |=> out_valid)
		else $error("result not presented");
endmodule
